// File: rtl/ldp_pkg.sv
// ----------------------------------------------------------------------------
// Lift/drag polar package
// Shared types, constants and register codes of the lift/drag polar unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ldp_pkg;

    // Number of quotient bits resolved by the divider chain, one per cell.
    localparam int QuotBits = 22;

    // Gravity, 9.81 in Q4.16.
    localparam logic [19:0] GRAV_Q16 = 20'd642908;

    // Register reset values.
    localparam logic [23:0]        REF_AREA_RST = 24'd256;
    localparam logic [15:0]        K_RST        = 16'd3277;
    localparam logic [15:0]        CD0_RST      = 16'd1311;
    localparam logic signed [20:0] CL_LO_RST    = -21'sd65536;
    localparam logic signed [20:0] CL_HI_RST    = 21'sd98304;
    localparam logic signed [21:0] N_LO_RST     = -22'sd131072;
    localparam logic signed [21:0] N_HI_RST     = 22'sd262144;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_REF_AREA = 3'd0,
        CFG_K        = 3'd1,
        CFG_CD0      = 3'd2,
        CFG_CL_LO    = 3'd3,
        CFG_CL_HI    = 3'd4,
        CFG_N_LO     = 3'd5,
        CFG_N_HI     = 3'd6
    } cfg_idx_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [23:0]        ref_area;
        logic [15:0]        k;
        logic [15:0]        cd0;
        logic signed [20:0] cl_lo;
        logic signed [20:0] cl_hi;
        logic signed [21:0] n_lo;
        logic signed [21:0] n_hi;
    } ldp_cfg_t;

    // Per-item flags and dynamic pressure that ride along the divider chain.
    typedef struct packed {
        logic        neg;
        logic        lr_zero;
        logic        d_zero;
        logic        sat;
        logic [39:0] q;
    } ldp_side_t;

endpackage

`default_nettype wire

// File: rtl/ldp_front.sv
// ----------------------------------------------------------------------------
// Lift/drag polar front end
// Six-stage pipeline forming dynamic pressure, required lift and q*S.
// ----------------------------------------------------------------------------
`default_nettype none

module ldp_front
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire [27:0]             airspeed,
    input  wire [19:0]             air_density,
    input  wire signed [21:0]      load_factor,
    input  wire [27:0]             mass,
    input  ldp_pkg::ldp_cfg_t      cfg,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic [63:0]            out_rem,
    output logic [63:0]            out_div,
    output ldp_pkg::ldp_side_t     out_side
);

    logic [5:0] v_reg;
    logic [5:0] ld;

    // Stage 1
    logic [55:0] s1_v2_reg,  s1_v2_next;
    logic [19:0] s1_rho_reg;
    logic [49:0] s1_nm_reg,  s1_nm_next;
    logic        s1_neg_reg, s1_neg_next;
    // Stage 2
    logic [47:0] s2_qh_reg, s2_ql_reg;
    logic [44:0] s2_gh_reg, s2_gl_reg;
    logic        s2_neg_reg;
    // Stage 3
    logic [39:0] s3_q_reg,  s3_q_next;
    logic [37:0] s3_lr_reg, s3_lr_next;
    logic        s3_neg_reg;
    // Stage 4
    logic [43:0] s4_dh_reg, s4_dl_reg;
    logic [39:0] s4_q_reg;
    logic [37:0] s4_lr_reg;
    logic        s4_neg_reg;
    // Stage 5
    logic [63:0] s5_d_reg;
    logic [39:0] s5_q_reg;
    logic [37:0] s5_lr_reg;
    logic        s5_neg_reg;
    // Stage 6
    logic [63:0]        s6_rem_reg, s6_rem_next;
    logic [63:0]        s6_d_reg;
    ldp_pkg::ldp_side_t s6_side_reg, s6_side_next;

    logic signed [21:0] n_min;
    logic signed [21:0] n_cl;
    logic [21:0]        nmag;
    logic [76:0]        qsum;
    logic [70:0]        lsum;
    logic [47:0]        lr_shift;

    always_comb
    begin
        ld[5] = !v_reg[5] || out_ready;
        for (int i = 4; i >= 0; i--)
        begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < 6; i++)
            begin
                if (ld[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 1: clamp the load factor, square the airspeed, form n*m.
    always_comb
    begin
        n_min       = (load_factor > cfg.n_hi) ? cfg.n_hi : load_factor;
        n_cl        = (n_min < cfg.n_lo) ? cfg.n_lo : n_min;
        s1_neg_next = n_cl[21];
        nmag        = n_cl[21] ? 22'(-n_cl) : n_cl;
        s1_v2_next  = 56'(airspeed) * 56'(airspeed);
        s1_nm_next  = 50'(nmag) * 50'(mass);
    end

    // Stage 3: assemble q = rho*V^2/2 and the required lift in Q.8.
    always_comb
    begin
        qsum       = {1'b0, s2_qh_reg, 28'd0} + 77'(s2_ql_reg);
        s3_q_next  = (|qsum[76:73]) ? {40{1'b1}} : qsum[72:33];
        lsum       = {1'b0, s2_gh_reg, 25'd0} + 71'(s2_gl_reg);
        s3_lr_next = lsum[69:32];
    end

    // Stage 6: detect the special cases and seed the divider remainder.
    always_comb
    begin
        lr_shift             = {s5_lr_reg, 10'd0};
        s6_side_next.neg     = s5_neg_reg;
        s6_side_next.lr_zero = (s5_lr_reg == '0);
        s6_side_next.d_zero  = (s5_d_reg == '0);
        s6_side_next.sat     = (64'(lr_shift) >= s5_d_reg);
        s6_side_next.q       = s5_q_reg;
        s6_rem_next          = s6_side_next.sat ? 64'd0 : 64'(lr_shift);
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s1_v2_reg  <= s1_v2_next;
            s1_rho_reg <= air_density;
            s1_nm_reg  <= s1_nm_next;
            s1_neg_reg <= s1_neg_next;
        end
        if (ld[1])
        begin
            s2_qh_reg  <= 48'(s1_rho_reg) * 48'(s1_v2_reg[55:28]);
            s2_ql_reg  <= 48'(s1_rho_reg) * 48'(s1_v2_reg[27:0]);
            s2_gh_reg  <= 45'(ldp_pkg::GRAV_Q16) * 45'(s1_nm_reg[49:25]);
            s2_gl_reg  <= 45'(ldp_pkg::GRAV_Q16) * 45'(s1_nm_reg[24:0]);
            s2_neg_reg <= s1_neg_reg;
        end
        if (ld[2])
        begin
            s3_q_reg   <= s3_q_next;
            s3_lr_reg  <= s3_lr_next;
            s3_neg_reg <= s2_neg_reg;
        end
        if (ld[3])
        begin
            s4_dh_reg  <= 44'(cfg.ref_area) * 44'(s3_q_reg[39:20]);
            s4_dl_reg  <= 44'(cfg.ref_area) * 44'(s3_q_reg[19:0]);
            s4_q_reg   <= s3_q_reg;
            s4_lr_reg  <= s3_lr_reg;
            s4_neg_reg <= s3_neg_reg;
        end
        if (ld[4])
        begin
            s5_d_reg   <= {s4_dh_reg, 20'd0} + 64'(s4_dl_reg);
            s5_q_reg   <= s4_q_reg;
            s5_lr_reg  <= s4_lr_reg;
            s5_neg_reg <= s4_neg_reg;
        end
        if (ld[5])
        begin
            s6_rem_reg  <= s6_rem_next;
            s6_d_reg    <= s5_d_reg;
            s6_side_reg <= s6_side_next;
        end
    end

    assign out_rem  = s6_rem_reg;
    assign out_div  = s6_d_reg;
    assign out_side = s6_side_reg;

endmodule

`default_nettype wire

// File: rtl/ldp_div_cell.sv
// ----------------------------------------------------------------------------
// Lift/drag polar divider cell
// One restoring division step: shift, trial subtract, one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ldp_div_cell
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire [63:0]                   in_rem,
    input  wire [63:0]                   in_div,
    input  wire [ldp_pkg::QuotBits-1:0]  in_quot,
    input  ldp_pkg::ldp_side_t           in_side,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [63:0]                  out_rem,
    output logic [63:0]                  out_div,
    output logic [ldp_pkg::QuotBits-1:0] out_quot,
    output ldp_pkg::ldp_side_t           out_side
);

    logic                          v_reg;
    logic                          ld;
    logic [64:0]                   shifted;
    logic [64:0]                   diff;
    logic                          take;
    logic [63:0]                   rem_next;
    logic [63:0]                   rem_reg;
    logic [63:0]                   div_reg;
    logic [ldp_pkg::QuotBits-1:0]  quot_reg;
    ldp_pkg::ldp_side_t            side_reg;

    assign ld       = !v_reg || out_ready;
    assign in_ready = ld;

    // The remainder stays below the divisor, so the result fits 64 bits.
    always_comb
    begin
        shifted  = {in_rem, 1'b0};
        diff     = shifted - {1'b0, in_div};
        take     = !diff[64];
        rem_next = take ? diff[63:0] : shifted[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (ld)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            rem_reg  <= rem_next;
            div_reg  <= in_div;
            quot_reg <= {in_quot[ldp_pkg::QuotBits-2:0], take};
            side_reg <= in_side;
        end
    end

    assign out_valid = v_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_quot  = quot_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// File: rtl/ldp_back.sv
// ----------------------------------------------------------------------------
// Lift/drag polar back end
// Six-stage pipeline: CL select and clamp, drag polar, lift and drag forces.
// ----------------------------------------------------------------------------
`default_nettype none

module ldp_back
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire [63:0]                   in_div,
    input  wire [ldp_pkg::QuotBits-1:0]  in_quot,
    input  ldp_pkg::ldp_side_t           in_side,
    input  ldp_pkg::ldp_cfg_t            cfg,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic signed [20:0]           lift_coeff,
    output logic [23:0]                  drag_coeff,
    output logic [39:0]                  dyn_pressure,
    output logic [39:0]                  lift_force,
    output logic [39:0]                  drag_force,
    output logic                         zero_pressure
);

    logic [5:0] v_reg;
    logic [5:0] ld;

    // Stage 1
    logic [20:0] b1_cl_reg,   b1_cl_next;
    logic [20:0] b1_mag_reg,  b1_mag_next;
    logic [63:0] b1_d_reg;
    logic [39:0] b1_q_reg;
    logic        b1_zp_reg;
    // Stage 2
    logic [40:0] b2_sq_reg;
    logic [52:0] b2_lh_reg, b2_ll_reg;
    logic [20:0] b2_cl_reg;
    logic [63:0] b2_d_reg;
    logic [39:0] b2_q_reg;
    logic        b2_zp_reg;
    // Stage 3
    logic [35:0] b3_kh_reg;
    logic [36:0] b3_kl_reg;
    logic [39:0] b3_lift_reg, b3_lift_next;
    logic [20:0] b3_cl_reg;
    logic [63:0] b3_d_reg;
    logic [39:0] b3_q_reg;
    logic        b3_zp_reg;
    // Stage 4
    logic [23:0] b4_cd_reg, b4_cd_next;
    logic [39:0] b4_lift_reg;
    logic [20:0] b4_cl_reg;
    logic [63:0] b4_d_reg;
    logic [39:0] b4_q_reg;
    logic        b4_zp_reg;
    // Stage 5
    logic [55:0] b5_dh_reg, b5_dl_reg;
    logic [23:0] b5_cd_reg;
    logic [39:0] b5_lift_reg;
    logic [20:0] b5_cl_reg;
    logic [39:0] b5_q_reg;
    logic        b5_zp_reg;
    // Stage 6, the output register
    logic [39:0] b6_drag_reg, b6_drag_next;
    logic [23:0] b6_cd_reg;
    logic [39:0] b6_lift_reg;
    logic [20:0] b6_cl_reg;
    logic [39:0] b6_q_reg;
    logic        b6_zp_reg;

    logic signed [23:0] clo24;
    logic signed [23:0] chi24;
    logic signed [23:0] mag24;
    logic signed [23:0] cl_raw;
    logic signed [23:0] cl_min;
    logic signed [23:0] cl_fin;
    logic [52:0]        lmag;
    logic [56:0]        ksum;
    logic [25:0]        cd_full;
    logic [55:0]        dsum;

    always_comb
    begin
        ld[5] = !v_reg[5] || out_ready;
        for (int i = 4; i >= 0; i--)
        begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < 6; i++)
            begin
                if (ld[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 1: pick the raw CL (quotient, bound or zero) and clamp it.
    always_comb
    begin
        clo24 = {{3{cfg.cl_lo[20]}}, cfg.cl_lo};
        chi24 = {{3{cfg.cl_hi[20]}}, cfg.cl_hi};
        mag24 = in_side.sat ? (24'sd1 <<< ldp_pkg::QuotBits) : 24'(in_quot);
        if (in_side.d_zero)
        begin
            cl_raw = in_side.lr_zero ? 24'sd0 : (in_side.neg ? clo24 : chi24);
        end
        else if (in_side.lr_zero)
        begin
            cl_raw = 24'sd0;
        end
        else
        begin
            cl_raw = in_side.neg ? -mag24 : mag24;
        end
        cl_min      = (cl_raw > chi24) ? chi24 : cl_raw;
        cl_fin      = (cl_min < clo24) ? clo24 : cl_min;
        b1_cl_next  = cl_fin[20:0];
        b1_mag_next = cl_fin[23] ? 21'(-cl_fin) : cl_fin[20:0];
    end

    // Stage 3: lift magnitude and its saturation by sign.
    always_comb
    begin
        lmag = b2_lh_reg + 53'(b2_ll_reg[52:32]);
        if (b2_cl_reg[20])
        begin
            b3_lift_next = 40'd0 - ((lmag > (53'd1 << 39)) ? 40'h80_0000_0000 : lmag[39:0]);
        end
        else
        begin
            b3_lift_next = (lmag > 53'h7F_FFFF_FFFF) ? 40'h7F_FFFF_FFFF : lmag[39:0];
        end
    end

    // Stage 4: CD = CD0 + K*CL^2, saturating.
    always_comb
    begin
        ksum       = {b3_kh_reg, 21'd0} + 57'(b3_kl_reg);
        cd_full    = 26'(cfg.cd0) + 26'(ksum[56:32]);
        b4_cd_next = (|cd_full[25:24]) ? 24'hFF_FFFF : cd_full[23:0];
    end

    // Stage 6: drag force, saturating.
    always_comb
    begin
        dsum         = b5_dh_reg + 56'(b5_dl_reg[55:32]);
        b6_drag_next = (|dsum[55:40]) ? {40{1'b1}} : dsum[39:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            b1_cl_reg  <= b1_cl_next;
            b1_mag_reg <= b1_mag_next;
            b1_d_reg   <= in_div;
            b1_q_reg   <= in_side.q;
            b1_zp_reg  <= in_side.d_zero;
        end
        if (ld[1])
        begin
            b2_sq_reg <= 41'(b1_mag_reg) * 41'(b1_mag_reg);
            b2_lh_reg <= 53'(b1_mag_reg) * 53'(b1_d_reg[63:32]);
            b2_ll_reg <= 53'(b1_mag_reg) * 53'(b1_d_reg[31:0]);
            b2_cl_reg <= b1_cl_reg;
            b2_d_reg  <= b1_d_reg;
            b2_q_reg  <= b1_q_reg;
            b2_zp_reg <= b1_zp_reg;
        end
        if (ld[2])
        begin
            b3_kh_reg   <= 36'(cfg.k) * 36'(b2_sq_reg[40:21]);
            b3_kl_reg   <= 37'(cfg.k) * 37'(b2_sq_reg[20:0]);
            b3_lift_reg <= b3_lift_next;
            b3_cl_reg   <= b2_cl_reg;
            b3_d_reg    <= b2_d_reg;
            b3_q_reg    <= b2_q_reg;
            b3_zp_reg   <= b2_zp_reg;
        end
        if (ld[3])
        begin
            b4_cd_reg   <= b4_cd_next;
            b4_lift_reg <= b3_lift_reg;
            b4_cl_reg   <= b3_cl_reg;
            b4_d_reg    <= b3_d_reg;
            b4_q_reg    <= b3_q_reg;
            b4_zp_reg   <= b3_zp_reg;
        end
        if (ld[4])
        begin
            b5_dh_reg   <= 56'(b4_cd_reg) * 56'(b4_d_reg[63:32]);
            b5_dl_reg   <= 56'(b4_cd_reg) * 56'(b4_d_reg[31:0]);
            b5_cd_reg   <= b4_cd_reg;
            b5_lift_reg <= b4_lift_reg;
            b5_cl_reg   <= b4_cl_reg;
            b5_q_reg    <= b4_q_reg;
            b5_zp_reg   <= b4_zp_reg;
        end
        if (ld[5])
        begin
            b6_drag_reg <= b6_drag_next;
            b6_cd_reg   <= b5_cd_reg;
            b6_lift_reg <= b5_lift_reg;
            b6_cl_reg   <= b5_cl_reg;
            b6_q_reg    <= b5_q_reg;
            b6_zp_reg   <= b5_zp_reg;
        end
    end

    assign lift_coeff    = b6_cl_reg;
    assign drag_coeff    = b6_cd_reg;
    assign dyn_pressure  = b6_q_reg;
    assign lift_force    = b6_lift_reg;
    assign drag_force    = b6_drag_reg;
    assign zero_pressure = b6_zp_reg;

endmodule

`default_nettype wire

// File: rtl/lift_drag_polar_unit_top.sv
// ----------------------------------------------------------------------------
// Lift/drag polar unit
// Dynamic pressure, clamped lift coefficient, parabolic drag polar and forces.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Beat contents
// s_axis    in         airspeed, air_density, load_factor, mass
// m_axis    out        lift_coeff, drag_coeff, dyn_pressure, lift_force,
//                      drag_force; zero_pressure in tuser
// cfg       in         register index and write data, always ready
//
// One beat is accepted every cycle unless back-pressure on m_axis has filled the
// pipeline; each beat gives one result beat after six front stages, one divider
// cell per quotient bit (22 cells), and six back stages.
// Reset clears the valid bits of every stage and loads the register defaults.
// Every stage holds its item only while the stage after it is full and
// stalled, so bubbles close up and input flows while a result waits.
//
`default_nettype none

module lift_drag_polar_unit_top
(
    input  wire          clk,
    input  wire          rst_n,
    // Input stream
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // [27:0] airspeed, [47:28] air_density, [69:48] load_factor,
    // [97:70] mass, [103:98] zero fill
    input  wire [103:0]  s_axis_tdata,
    // Output stream
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [20:0] lift_coeff, [44:21] drag_coeff, [84:45] dyn_pressure,
    // [124:85] lift_force, [164:125] drag_force, [167:165] zero fill
    output logic [167:0] m_axis_tdata,
    // [0] zero_pressure
    output logic [0:0]   m_axis_tuser,
    // Configuration writes
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire [2:0]    cfg_index,
    input  wire [23:0]   cfg_data
);

    localparam int NCells = ldp_pkg::QuotBits;

    ldp_pkg::ldp_cfg_t cfg_reg;

    // Configuration registers. The user writes only while the pipeline is idle; not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_area <= ldp_pkg::REF_AREA_RST;
            cfg_reg.k        <= ldp_pkg::K_RST;
            cfg_reg.cd0      <= ldp_pkg::CD0_RST;
            cfg_reg.cl_lo    <= ldp_pkg::CL_LO_RST;
            cfg_reg.cl_hi    <= ldp_pkg::CL_HI_RST;
            cfg_reg.n_lo     <= ldp_pkg::N_LO_RST;
            cfg_reg.n_hi     <= ldp_pkg::N_HI_RST;
        end
        else if (cfg_valid)
        begin
            unique case (ldp_pkg::cfg_idx_t'(cfg_index))
                ldp_pkg::CFG_REF_AREA: cfg_reg.ref_area <= cfg_data;
                ldp_pkg::CFG_K:        cfg_reg.k        <= cfg_data[15:0];
                ldp_pkg::CFG_CD0:      cfg_reg.cd0      <= cfg_data[15:0];
                ldp_pkg::CFG_CL_LO:    cfg_reg.cl_lo    <= cfg_data[20:0];
                ldp_pkg::CFG_CL_HI:    cfg_reg.cl_hi    <= cfg_data[20:0];
                ldp_pkg::CFG_N_LO:     cfg_reg.n_lo     <= cfg_data[21:0];
                ldp_pkg::CFG_N_HI:     cfg_reg.n_hi     <= cfg_data[21:0];
                default:               cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // Divider chain wiring; index 0 is fed by the front end.
    logic                          chain_valid [0:NCells];
    logic                          chain_ready [0:NCells];
    logic [63:0]                   chain_rem   [0:NCells];
    logic [63:0]                   chain_div   [0:NCells];
    logic [ldp_pkg::QuotBits-1:0]  chain_quot  [0:NCells];
    ldp_pkg::ldp_side_t            chain_side  [0:NCells];

    logic signed [20:0] lift_coeff;
    logic [23:0]        drag_coeff;
    logic [39:0]        dyn_pressure;
    logic [39:0]        lift_force;
    logic [39:0]        drag_force;
    logic               zero_pressure;

    ldp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .airspeed    (s_axis_tdata[27:0]),
        .air_density (s_axis_tdata[47:28]),
        .load_factor (s_axis_tdata[69:48]),
        .mass        (s_axis_tdata[97:70]),
        .cfg         (cfg_reg),
        .out_valid   (chain_valid[0]),
        .out_ready   (chain_ready[0]),
        .out_rem     (chain_rem[0]),
        .out_div     (chain_div[0]),
        .out_side    (chain_side[0])
    );

    // The quotient starts empty; each cell shifts in one bit, MSB first.
    assign chain_quot[0] = '0;

    for (genvar g = 0; g < NCells; g++)
    begin : g_cell
        ldp_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_rem    (chain_rem[g]),
            .in_div    (chain_div[g]),
            .in_quot   (chain_quot[g]),
            .in_side   (chain_side[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_rem   (chain_rem[g+1]),
            .out_div   (chain_div[g+1]),
            .out_quot  (chain_quot[g+1]),
            .out_side  (chain_side[g+1])
        );
    end

    // The final remainder is not needed; the quotient, divisor and side data move on.
    ldp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (chain_valid[NCells]),
        .in_ready      (chain_ready[NCells]),
        .in_div        (chain_div[NCells]),
        .in_quot       (chain_quot[NCells]),
        .in_side       (chain_side[NCells]),
        .cfg           (cfg_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .lift_coeff    (lift_coeff),
        .drag_coeff    (drag_coeff),
        .dyn_pressure  (dyn_pressure),
        .lift_force    (lift_force),
        .drag_force    (drag_force),
        .zero_pressure (zero_pressure)
    );

    assign m_axis_tdata = {3'd0, drag_force, lift_force, dyn_pressure, drag_coeff,
                           lift_coeff};
    assign m_axis_tuser = zero_pressure;

endmodule

`default_nettype wire

// File: rtl/lift_drag_polar_unit_checker.sv
// ----------------------------------------------------------------------------
// Lift/drag polar checker
// Port-level properties of the lift/drag polar unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lift_drag_polar_unit_checker
(
    input wire         clk,
    input wire         rst_n,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [167:0] m_axis_tdata,
    input wire [0:0]   m_axis_tuser
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its contents.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // With no dynamic pressure there is no lift and no drag.
    a_zero_forces: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[164:85] == '0)
        else $error("forces nonzero at zero dynamic pressure");

    // A nonnegative lift coefficient never gives a negative lift force.
    a_lift_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[20] |-> !m_axis_tdata[124])
        else $error("lift force sign disagrees with lift coefficient");

endmodule

bind lift_drag_polar_unit_top lift_drag_polar_unit_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
